FILE: src/srle_pkg.sv
package srle_pkg;

   localparam int QueueDepthDefault = 2;

   localparam logic [7:0] CodeEol   = 8'h00;
   localparam logic [7:0] CodeLitMax = 8'h7F;
   localparam logic [7:0] CodeXLit  = 8'h80;
   localparam logic [7:0] CodeXSkip = 8'hFF;

   localparam logic RegFormat = 1'b0;
   localparam logic RegWidth  = 1'b1;

   localparam logic FmtByteCode = 1'b0;

   typedef enum logic [2:0] {
      PH_CTRL      = 3'd0,
      PH_LIT       = 3'd1,
      PH_XLIT_CNT  = 3'd2,
      PH_XSKIP_CNT = 3'd3,
      PH_REP_COLOR = 3'd4,
      PH_IDLE      = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in_line;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] column;
      logic [6:0]  run_length;
      logic [7:0]  pixel_value;
      logic        line_done;
   } rsp_type;

   // Run command from the decoder to the output side
   typedef struct packed {
      logic        write_enable;
      logic [15:0] column;
      logic [6:0]  run_length;
      logic [7:0]  pixel_value;
      logic        line_done;
   } cmd_type;

endpackage

FILE: src/srle_front.sv
module srle_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             fmt,
   input  logic [15:0]      width,
   input  logic             req_valid,
   input  srle_pkg::req_type req_payload,
   input  logic             queue_full,
   output logic             cmd_valid,
   output srle_pkg::cmd_type cmd
);
   import srle_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  pending_ff, pending_in;
   logic [16:0] column_ff, column_in;

   logic        active;
   logic [16:0] width_x;
   logic [16:0] room;
   logic [16:0] rep_len;
   logic [7:0]  b;
   logic [16:0] col_sum;
   logic [7:0]  pending_dec;

   assign b           = req_payload.data_byte;
   assign cmd_valid   = req_valid && !queue_full;
   assign width_x     = {1'b0, width};
   assign active      = (phase_ff != PH_IDLE) && (column_ff < width_x);
   assign room        = width_x - column_ff;
   assign rep_len     = ({9'd0, pending_ff} > room) ? room : {9'd0, pending_ff};
   assign pending_dec = pending_ff - 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CTRL;
         pending_ff <= '0;
         column_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         column_ff  <= column_in;
      end
   end

   // next state
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      col_sum    = column_ff;
      if (cmd_valid && active) begin
         unique case (phase_ff)
            PH_CTRL: begin
               if (fmt == FmtByteCode) begin
                  priority if (b == CodeEol) begin
                     phase_in = PH_IDLE;
                  end else if (b <= CodeLitMax) begin
                     pending_in = b;
                     phase_in   = PH_LIT;
                  end else if (b == CodeXLit) begin
                     phase_in = PH_XLIT_CNT;
                  end else if (b == CodeXSkip) begin
                     phase_in = PH_XSKIP_CNT;
                  end else begin
                     col_sum = column_ff + {10'd0, b[6:0]};
                  end
               end else if (b[0]) begin
                  col_sum = column_ff + {10'd0, b[7:1]};
               end else begin
                  pending_in = {2'b00, b[7:2]} + 8'd1;
                  phase_in   = b[1] ? PH_REP_COLOR : PH_LIT;
               end
            end
            PH_LIT: begin
               col_sum    = column_ff + 17'd1;
               pending_in = pending_dec;
               if (pending_dec == 8'd0) begin
                  phase_in = PH_CTRL;
               end
            end
            PH_XLIT_CNT: begin
               pending_in = b;
               phase_in   = (b == 8'd0) ? PH_CTRL : PH_LIT;
            end
            PH_XSKIP_CNT: begin
               col_sum  = column_ff + {9'd0, b};
               phase_in = PH_CTRL;
            end
            PH_REP_COLOR: begin
               col_sum    = column_ff + rep_len;
               pending_in = '0;
               phase_in   = PH_CTRL;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (col_sum >= width_x) begin
            phase_in = PH_IDLE;
         end
      end
      column_in = col_sum;
      if (cmd_valid && req_payload.last_in_line) begin
         phase_in   = PH_CTRL;
         pending_in = '0;
         column_in  = '0;
      end
   end

   // run command
   always_comb begin
      cmd              = '0;
      cmd.line_done    = req_payload.last_in_line;
      cmd.column       = column_ff[15:0];
      cmd.pixel_value  = b;
      if (active) begin
         unique case (phase_ff)
            PH_LIT: begin
               cmd.write_enable = 1'b1;
               cmd.run_length   = 7'd1;
            end
            PH_REP_COLOR: begin
               cmd.write_enable = (rep_len != 17'd0);
               cmd.run_length   = rep_len[6:0];
            end
            default: begin
               cmd.write_enable = 1'b0;
            end
         endcase
      end
   end

endmodule

FILE: src/srle_queue.sv
module srle_queue #(
   parameter int DEPTH = srle_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srle_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output srle_pkg::cmd_type head
);
   import srle_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/srle_back.sv
module srle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  srle_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srle_pkg::rsp_type rsp_payload
);
   import srle_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    load;

   assign load    = cmd_valid && (!valid_ff || !rsp_stall);
   assign cmd_pop = load;

   // column, run length and pixel value of a result without a write read as zero
   always_comb begin
      data_in              = '0;
      data_in.write_enable = cmd.write_enable;
      data_in.line_done    = cmd.line_done;
      if (cmd.write_enable) begin
         data_in.column      = cmd.column;
         data_in.run_length  = cmd.run_length;
         data_in.pixel_value = cmd.pixel_value;
      end
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

FILE: src/sprite_rle_scanline_decoder_unit.sv
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_stall | srle_pkg::req_type (byte, last flag)
// rsp      | out       | rsp_valid / rsp_stall | srle_pkg::rsp_type (one run per byte)
// csr      | in/out    | psel/penable/pready   | rle_format @0x0, line_width @0x4
//
// One item per cycle while req_stall is low; the decoder state (phase, pending count,
// column) updates in the same cycle the byte is taken, and each run goes from
// accept to rsp_valid through the run queue, then the output register.
// Synchronous active-high reset clears decoder state, queue and output valid;
// rle_format and line_width come up as 1.
// req_stall rises only when the run queue is full, i.e. after rsp_stall has
// held long enough to back up QUEUE_DEPTH items plus the output register.
module sprite_rle_scanline_decoder_unit #(
   parameter int QUEUE_DEPTH = srle_pkg::QueueDepthDefault  // 2 or more
) (
   input  logic              clock,
   input  logic              reset,
   // input byte stream
   input  logic              req_valid,
   output logic              req_stall,
   input  srle_pkg::req_type req_payload,
   // run results
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srle_pkg::rsp_type rsp_payload,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import srle_pkg::*;

   logic        fmt_ff, fmt_in;
   logic [15:0] width_ff, width_in;
   logic        reg_sel;
   logic        reg_write;

   logic    queue_full;
   logic    front_valid;
   cmd_type front_cmd;
   logic    queue_not_empty;
   cmd_type queue_head;
   logic    queue_pop;

   // ---------------------------------------------------------------
   // Register port: word index is paddr[2]; always ready.
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign reg_write = psel && penable && pwrite;

   always_comb begin
      fmt_in   = fmt_ff;
      width_in = width_ff;
      if (reg_write) begin
         unique case (reg_sel)
            RegFormat: fmt_in   = pwdata[0];
            RegWidth:  width_in = pwdata[15:0];
            default:   fmt_in   = fmt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= 1'b1;
         width_ff <= 16'd1;
      end else begin
         fmt_ff   <= fmt_in;
         width_ff <= width_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         RegFormat: prdata = {31'd0, fmt_ff};
         RegWidth:  prdata = {16'd0, width_ff};
         default:   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Front: parse each byte, track column and clip runs to the width.
   // A byte is taken whenever the queue has room.
   // ---------------------------------------------------------------
   assign req_stall = queue_full;

   srle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .fmt         (fmt_ff),
      .width       (width_ff),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .cmd_valid   (front_valid),
      .cmd         (front_cmd)
   );

   // Run queue decouples parsing from the result side.
   srle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // Back: output register, zeroes unused fields on non-writes.
   srle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (queue_not_empty),
      .cmd         (queue_head),
      .cmd_pop     (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: dv/sprite_rle_scanline_decoder_unit_tb.sv
`timescale 1ns / 1ps

module sprite_rle_scanline_decoder_unit_tb;
   import srle_pkg::*;

   // Scoreboard: tracks the decoder state from the accepted bytes and holds
   // the run each byte should produce, oldest first.
   class run_scoreboard;
      rsp_type     expected_runs[$];
      int          errors;
      logic        fmt;
      logic [15:0] width;
      phase_type   phase;
      logic [7:0]  pending;
      logic [16:0] next_col;

      function new();
         errors = 0;
         fmt    = 1'b1;
         width  = 16'd1;
         restart_line();
      endfunction

      function void restart_line();
         phase    = PH_CTRL;
         pending  = '0;
         next_col = '0;
      endfunction

      function void write_reg(logic idx, logic [31:0] value);
         if (idx == RegFormat) begin
            fmt = value[0];
         end else begin
            width = value[15:0];
         end
      endfunction

      // Decode one accepted byte and queue the run it produces.
      function void note_byte(req_type it);
         rsp_type     run;
         logic [7:0]  b;
         int unsigned col;
         int unsigned room;
         int unsigned len;
         run = '0;
         b = it.data_byte;
         run.line_done = it.last_in_line;
         if (phase != PH_IDLE && next_col < width) begin
            col  = next_col;
            room = width - col;
            case (phase)
               PH_CTRL: begin
                  if (fmt == FmtByteCode) begin
                     if (b == CodeEol) begin
                        phase = PH_IDLE;
                     end else if (b <= CodeLitMax) begin
                        pending = b;
                        phase   = PH_LIT;
                     end else if (b == CodeXLit) begin
                        phase = PH_XLIT_CNT;
                     end else if (b == CodeXSkip) begin
                        phase = PH_XSKIP_CNT;
                     end else begin
                        col += b - CodeXLit;
                     end
                  end else begin
                     if (b[0]) begin
                        col += b >> 1;
                     end else begin
                        pending = (b >> 2) + 8'd1;
                        phase   = b[1] ? PH_REP_COLOR : PH_LIT;
                     end
                  end
               end
               PH_LIT: begin
                  run.write_enable = 1'b1;
                  run.column       = 16'(col);
                  run.run_length   = 7'd1;
                  run.pixel_value  = b;
                  col += 1;
                  pending = pending - 8'd1;
                  if (pending == 8'd0) phase = PH_CTRL;
               end
               PH_XLIT_CNT: begin
                  pending = b;
                  phase   = (b == 8'd0) ? PH_CTRL : PH_LIT;
               end
               PH_XSKIP_CNT: begin
                  col += b;
                  phase = PH_CTRL;
               end
               PH_REP_COLOR: begin
                  len = pending;
                  if (len > room) len = room;
                  if (len != 0) begin
                     run.write_enable = 1'b1;
                     run.column       = 16'(col);
                     run.run_length   = 7'(len);
                     run.pixel_value  = b;
                     col += len;
                  end
                  pending = '0;
                  phase   = PH_CTRL;
               end
               default: phase = PH_IDLE;
            endcase
            if (col >= width) phase = PH_IDLE;
            next_col = 17'(col);
         end
         if (it.last_in_line) restart_line();
         expected_runs.push_back(run);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_run(rsp_type got);
         rsp_type want;
         if (expected_runs.size() == 0) begin
            report($sformatf("run %h with nothing expected", got));
         end else begin
            want = expected_runs.pop_front();
            if (got.write_enable !== want.write_enable)
               report($sformatf("write_enable %0b, want %0b", got.write_enable,
                                want.write_enable));
            if (got.column !== want.column)
               report($sformatf("column %0d, want %0d", got.column, want.column));
            if (got.run_length !== want.run_length)
               report($sformatf("run_length %0d, want %0d", got.run_length,
                                want.run_length));
            if (got.pixel_value !== want.pixel_value)
               report($sformatf("pixel_value %0h, want %0h", got.pixel_value,
                                want.pixel_value));
            if (got.line_done !== want.line_done)
               report($sformatf("line_done %0b, want %0b", got.line_done, want.line_done));
         end
      endtask
   endclass

   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 70;
   localparam int NumPhases  = 11;
   localparam int HoldCycles = 80;

   // Register settings per random phase; extremes of the width included.
   // Phase 1 carries the long receiver hold-off, phase 6 the drain pause,
   // phase 4 the line that walks the column up to the top of the range.
   int phase_fmt   [NumPhases] = '{0, 1, 0, 1, 0, 1, 1, 0, 0, 1, 0};
   int phase_width [NumPhases] = '{64, 40, 1, 0, 65535, 65535, 200, 16, 300, 9, 128};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   run_scoreboard sb;
   req_type       line_q[$];
   bit            quiet;         // no idling on either side
   bit            hold_request;  // sender asks the receiver for a long hold-off
   int            hold_left;
   int            stall_burst;
   int            cycle_count;
   int            phase_items;

   sprite_rle_scanline_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void push_byte(logic [7:0] b);
      req_type it;
      it.data_byte    = b;
      it.last_in_line = 1'b0;
      line_q.push_back(it);
   endfunction

   // Flag the final queued byte as the end of the line.
   function automatic void close_line();
      req_type tail;
      tail = line_q.pop_back();
      tail.last_in_line = 1'b1;
      line_q.push_back(tail);
   endfunction

   // Offer one item; it is noted once the handshake completes. Valid stays
   // high into the next item unless an idle burst is drawn.
   task automatic send_item(input req_type it);
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(it);
      phase_items++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_type it;
      it.data_byte    = b;
      it.last_in_line = last;
      send_item(it);
   endtask

   task automatic send_line();
      while (line_q.size() != 0) send_item(line_q.pop_front());
   endtask

   // Stop offering and wait until every expected run has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_runs.size() != 0) @(posedge clock);
   endtask

   // One register access: setup cycle then access cycle. psel stays up so
   // accesses can run back to back; the caller closes the bus.
   task automatic csr_access(input logic idx, input logic wr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wr ? value : 32'd0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (wr) begin
         sb.write_reg(idx, value);
      end else if (prdata !== value) begin
         sb.report($sformatf("register %0d reads %0h, want %0h", idx, prdata, value));
      end
   endtask

   task automatic configure(input logic fmt, input logic [15:0] width);
      wait_drained();
      csr_access(RegFormat, 1'b1, {31'd0, fmt});
      csr_access(RegWidth, 1'b1, {16'd0, width});
      csr_access(RegFormat, 1'b0, {31'd0, fmt});
      csr_access(RegWidth, 1'b0, {16'd0, width});
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Mostly well-formed lines with random content; some noise lines and
   // some lines cut short so runs end at the line boundary.
   task automatic build_line(input logic fmt);
      int unsigned ntok;
      int unsigned kind;
      int unsigned n;
      logic [5:0]  m;
      req_type     it;
      line_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            it.data_byte    = rand_byte();
            it.last_in_line = ($urandom_range(0, 3) == 0);
            line_q.push_back(it);
         end
      end else begin
         ntok = $urandom_range(1, 8);
         repeat (ntok) begin
            kind = $urandom_range(0, 9);
            if (fmt == FmtByteCode) begin
               case (kind)
                  0, 1, 2, 3: begin
                     n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127)
                                                       : $urandom_range(1, 6);
                     push_byte(8'(n));
                     repeat (n) push_byte(rand_byte());
                  end
                  4: begin
                     n = $urandom_range(0, 8);
                     push_byte(CodeXLit);
                     push_byte(8'(n));
                     repeat (n) push_byte(rand_byte());
                  end
                  5, 6: begin
                     n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125)
                                                      : $urandom_range(0, 5);
                     push_byte(8'h81 + 8'(n));
                  end
                  7: begin
                     n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 12);
                     push_byte(CodeXSkip);
                     push_byte(8'(n));
                  end
                  8: push_byte($urandom_range(0, 1) ? CodeEol : rand_byte());
                  default: push_byte(rand_byte());
               endcase
            end else begin
               case (kind)
                  0, 1, 2: begin
                     n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 6);
                     push_byte({n[6:0], 1'b1});
                  end
                  3, 4, 5: begin
                     n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 6);
                     m = 6'(n - 1);
                     push_byte({m, 2'b00});
                     repeat (n) push_byte(rand_byte());
                  end
                  6, 7, 8: begin
                     n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 10);
                     m = 6'(n - 1);
                     push_byte({m, 2'b10});
                     push_byte(rand_byte());
                  end
                  default: push_byte(rand_byte());
               endcase
            end
         end
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, line_q.size());
            while (line_q.size() > n) void'(line_q.pop_back());
         end
      end
      close_line();
   endtask

   // Byte-code line that skips out to 65406, then literals up to the width.
   task automatic build_far_line();
      line_q.delete();
      repeat (256) begin
         push_byte(CodeXSkip);
         push_byte(8'hFF);
      end
      push_byte(8'hFE);
      push_byte(CodeXLit);
      push_byte(8'hFF);
      repeat (140) push_byte(rand_byte());
      close_line();
   endtask

   task automatic run_directed();
      configure(FmtByteCode, 16'd8);
      // literal 2, skip 3, extended literal of 0, extended skip 1,
      // extended literal 1, literal 1 reaching the width, then ignored
      send_byte(8'h02, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(CodeXLit, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(CodeXSkip, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(CodeXLit, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h07, 1'b1);
      // end-of-line code, rest ignored
      send_byte(CodeEol, 1'b0);
      send_byte(8'h03, 1'b1);
      // line ends in the middle of a literal run
      send_byte(8'h05, 1'b0);
      send_byte(8'h66, 1'b1);
      // format switched while a byte-code literal is pending
      send_byte(8'h02, 1'b0);
      configure(~FmtByteCode, 16'd8);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h0A, 1'b0);
      send_byte(8'hFE, 1'b1);
      // flag scheme: skip 1, repeat 64 clipped to 7, then ignored
      send_byte(8'h03, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'h99, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic run_phase(input int p);
      bit pressure_done;
      pressure_done = 1'b0;
      quiet = (p == NumPhases - 1);
      configure(1'(phase_fmt[p]), 16'(phase_width[p]));
      if (p == 4) begin
         build_far_line();
         send_line();
      end
      phase_items = 0;
      while (phase_items < PhaseItems) begin
         if (!pressure_done && phase_items >= 30) begin
            pressure_done = 1'b1;
            if (p == 1) hold_request = 1'b1;  // block fills while sender keeps going
            if (p == 6) wait_drained();       // sender pause until all runs are back
         end
         build_line(1'(phase_fmt[p]));
         send_line();
      end
   endtask

   // Stimulus and end of run
   initial begin
      sb = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // registers come up as 1
      csr_access(RegFormat, 1'b0, 32'd1);
      csr_access(RegWidth, 1'b0, 32'd1);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < NumPhases; p++) run_phase(p);
      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Result side: check each accepted run, then pick the next stall value.
   // A hold-off request gives one long stall; otherwise random bursts.
   initial begin
      rsp_stall   <= 1'b0;
      hold_left   = 0;
      stall_burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_run(rsp_payload);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_burst > 0) begin
            stall_burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_burst = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   initial begin
      for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
src/srle_pkg.sv
src/srle_front.sv
src/srle_queue.sv
src/srle_back.sv
src/sprite_rle_scanline_decoder_unit.sv
dv/sprite_rle_scanline_decoder_unit_tb.sv
